>>> hdl/cstc_pkg.sv
package cstc_pkg;

    // Character codes the compactor reacts to.
    localparam logic [7:0] CH_EOF   = 8'h1A;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Most characters one input item can produce.
    localparam int MaxOut = 4;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_SKIP    = 2'd1,
        MODE_COMMENT = 2'd2
    } cstc_mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } cstc_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } cstc_out_t;

    typedef struct packed {
        cstc_mode_t scan_mode;
        logic       in_quotes;
        logic       in_section_name;
        logic       held_valid;
        logic [7:0] held_char;
    } cstc_state_t;

    localparam cstc_state_t StateReset = '{
        scan_mode:       MODE_NORMAL,
        in_quotes:       1'b0,
        in_section_name: 1'b0,
        held_valid:      1'b0,
        held_char:       CH_NUL
    };

    typedef logic [MaxOut-1:0][7:0] cstc_chars_t;

    // Characters produced by one item, oldest in entry 0.
    typedef struct packed {
        cstc_chars_t chars;
        logic [2:0]  count;
    } cstc_burst_t;

endpackage

>>> hdl/cstc_step_logic.sv
module cstc_step_logic (
    input  cstc_pkg::cstc_in_t    item,
    input  cstc_pkg::cstc_state_t state,
    output cstc_pkg::cstc_state_t state_next,
    output cstc_pkg::cstc_burst_t burst
);
    import cstc_pkg::*;

    typedef struct packed {
        cstc_state_t st;
        cstc_chars_t chars;
        logic [2:0]  count;
    } acc_t;

    function automatic acc_t emit_c(acc_t a, logic [7:0] c);
        acc_t r;
        r = a;
        if (r.count < 3'(MaxOut))
        begin
            r.chars[r.count[1:0]] = c;
            r.count = r.count + 3'd1;
        end
        return r;
    endfunction

    // The new character replaces the held one, which goes out.
    function automatic acc_t put_c(acc_t a, logic [7:0] c);
        acc_t r;
        r = a;
        if (r.st.held_valid)
            r = emit_c(r, r.st.held_char);
        r.st.held_char  = c;
        r.st.held_valid = 1'b1;
        return r;
    endfunction

    function automatic acc_t handle_normal(acc_t a, logic [7:0] c);
        acc_t       r;
        logic [7:0] last;
        r    = a;
        last = r.st.held_valid ? r.st.held_char : CH_SPACE;
        case (c) inside
            CH_OPEN:
            begin
                r.st.in_section_name = 1'b1;
                r = put_c(r, c);
            end
            CH_CLOSE:
            begin
                // Inside a section name, a space just before the bracket is overwritten in place.
                if (r.st.in_section_name && r.st.held_valid && r.st.held_char == CH_SPACE)
                    r.st.held_char = c;
                else
                    r = put_c(r, c);
                r.st.in_section_name = 1'b0;
            end
            CH_CR:
            begin
            end
            CH_LF:
                r.st.scan_mode = MODE_SKIP;
            CH_TAB, CH_SPACE:
            begin
                if (r.st.in_section_name)
                begin
                    if (last != CH_SPACE && last != CH_CLOSE)
                        r = put_c(r, CH_SPACE);
                end
                else if (r.st.in_quotes)
                    r = put_c(r, c);
            end
            CH_QUOTE:
            begin
                r.st.in_quotes = ~r.st.in_quotes;
                r = put_c(r, c);
            end
            CH_SEMI:
                r.st.scan_mode = MODE_COMMENT;
            default:
                r = put_c(r, c);
        endcase
        return r;
    endfunction

    acc_t       acc;
    logic [7:0] c;

    always_comb
    begin
        c         = item.in_byte;
        acc.st    = state;
        acc.chars = '0;
        acc.count = 3'd0;
        if (item.end_of_file)
        begin
            if (acc.st.held_valid)
                acc = emit_c(acc, acc.st.held_char);
            acc    = emit_c(acc, CH_NUL);
            acc    = emit_c(acc, CH_NUL);
            acc    = emit_c(acc, CH_EOF);
            acc.st = StateReset;
        end
        else
        begin
            case (state.scan_mode)
                MODE_SKIP:
                begin
                    if (c != CH_LF && c != CH_CR && c != CH_SPACE && c != CH_TAB)
                    begin
                        if (c != CH_SEMI)
                            acc = put_c(acc, CH_NUL);
                        if (c == CH_OPEN)
                            acc = put_c(acc, CH_NUL);
                        acc.st.in_quotes = 1'b0;
                        acc.st.scan_mode = MODE_NORMAL;
                        acc = handle_normal(acc, c);
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF || c == CH_CR || c == CH_NUL || c == CH_EOF)
                    begin
                        acc.st.scan_mode = MODE_NORMAL;
                        acc = handle_normal(acc, c);
                    end
                end
                default:
                begin
                    acc.st.scan_mode = MODE_NORMAL;
                    acc = handle_normal(acc, c);
                end
            endcase
        end
    end

    assign state_next  = acc.st;
    assign burst.chars = acc.chars;
    assign burst.count = acc.count;

endmodule

>>> hdl/cstc_result_buf.sv
module cstc_result_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  cstc_pkg::cstc_burst_t burst,
    output logic                  free,
    output logic                  result_valid,
    input  logic                  result_ready,
    output cstc_pkg::cstc_out_t   result
);
    import cstc_pkg::*;

    cstc_chars_t chars_reg;
    logic [2:0]  count_reg, count_next;
    logic [1:0]  pos_reg, pos_next;
    logic        is_last;
    logic        take;

    assign result_valid       = (count_reg != 3'd0);
    assign is_last            = ({1'b0, pos_reg} == (count_reg - 3'd1));
    assign take               = result_valid && result_ready;
    assign free               = !result_valid || (take && is_last);
    assign result.out_char    = chars_reg[pos_reg];
    assign result.last_of_run = is_last;

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        if (take)
        begin
            if (is_last)
                count_next = 3'd0;
            else
                pos_next = pos_reg + 2'd1;
        end
        if (load && burst.count != 3'd0)
        begin
            count_next = burst.count;
            pos_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            pos_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && burst.count != 3'd0)
            chars_reg <= burst.chars;
    end

endmodule

>>> hdl/config_text_stream_compactor_core.sv
// Configuration text compactor. Each input transfer carries one raw byte of a text file,
// or an end marker (end_of_file = 1). Output transfers carry the compacted text: carriage
// returns, comments and unquoted blanks outside section names are removed, blanks in a
// section name shrink to one space, a line end becomes a zero byte, a zero byte is
// doubled before a section header, and the end marker flushes the text followed by 0, 0,
// 0x1A, after which the block is back in its reset state. The last character of each
// item's output carries last_of_run = 1. The block accepts one item per cycle as long as
// every item yields at most one character and result_ready stays high; an item that
// yields more characters holds the input until all have been sent (at most four, for
// the end marker). The input byte is registered, the step logic is combinational, and
// the characters are loaded into a four-entry result buffer.
module config_text_stream_compactor_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  cstc_pkg::cstc_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output cstc_pkg::cstc_out_t result
);
    import cstc_pkg::*;

    // Input register stage.
    logic        in_valid_reg, in_valid_next;
    cstc_in_t    in_item_reg;

    // Scanner state, updated once per processed item.
    cstc_state_t state_reg;
    cstc_state_t state_next;
    cstc_burst_t burst;

    logic        buf_free;
    logic        advance;
    logic        item_take;

    // The registered item moves on whenever the result buffer can take its burst,
    // which also frees the input register for the next transfer in the same cycle.
    assign advance    = in_valid_reg && buf_free;
    assign item_ready = !in_valid_reg || advance;
    assign item_take  = item_valid && item_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= StateReset;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            in_item_reg <= item;
    end

    cstc_step_logic u_step (
        .item       (in_item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .burst      (burst)
    );

    cstc_result_buf u_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .burst        (burst),
        .free         (buf_free),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // An end marker always leaves the scanner in its reset state.
    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.end_of_file |=> state_reg == StateReset)
        else $error("scanner state not cleared after end marker");

    // The input register never takes a new item while its own item is stuck.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !buf_free |-> !item_ready)
        else $error("input register overwritten while blocked");

    // An end marker always produces a burst closed by the file terminator.
    a_eof_burst: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.end_of_file |=>
            result_valid && u_buf.chars_reg[u_buf.count_reg[1:0] - 2'd1] == CH_EOF)
        else $error("end marker burst does not end in terminator");

endmodule
